// ----- rtl/itoa_pkg.sv -----
// ============================================================================
// itoa_pkg
// Shared constants and the digit-to-character mapping of the integer to
// ASCII converter.
// ============================================================================
`default_nettype none

package itoa_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int DIGIT_W             = 6;
    localparam int CHAR_W              = 7;

    localparam logic [DIGIT_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_DECIMAL = 6'd10;
    localparam logic [DIGIT_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE    = 6'd9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    // Digits ten and above become upper-case letters.
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d > DIGIT_NINE)
        begin
            return d_ext - {1'b0, RADIX_DECIMAL} + CHAR_A;
        end
        return d_ext + CHAR_ZERO;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/itoa_in_if.sv -----
// ============================================================================
// itoa_in_if
// Valid/ready channel carrying one signed integer per transfer.
// ============================================================================
`default_nettype none

interface itoa_in_if #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/itoa_out_if.sv -----
// ============================================================================
// itoa_out_if
// Valid/ready channel carrying one ASCII character and its last flag.
// ============================================================================
`default_nettype none

interface itoa_out_if;
    logic                          valid;
    logic                          ready;
    logic [itoa_pkg::CHAR_W-1:0]   character;
    logic                          last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/itoa_divider.sv -----
// ============================================================================
// itoa_divider
// Restoring divider, one quotient bit per cycle: divides a VALUE_WIDTH-bit
// magnitude by a radix of at most 36 and returns quotient and remainder.
// ============================================================================
`default_nettype none

module itoa_divider #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [VALUE_WIDTH-1:0]        dividend,
    input  wire logic [itoa_pkg::DIGIT_W-1:0]  divisor,
    output logic                               done,
    output logic [VALUE_WIDTH-1:0]             quotient,
    output logic [itoa_pkg::DIGIT_W-1:0]       remainder
);
    import itoa_pkg::*;

    localparam int IW = $clog2(VALUE_WIDTH);
    localparam logic [IW-1:0] LAST_STEP = IW'(VALUE_WIDTH - 1);

    logic                   busy_reg,  busy_next;
    logic                   done_reg,  done_next;
    logic [IW-1:0]          cnt_reg,   cnt_next;
    logic [VALUE_WIDTH-1:0] q_reg,     q_next;
    logic [DIGIT_W-1:0]     rem_reg,   rem_next;
    logic [DIGIT_W-1:0]     div_reg,   div_next;
    logic [DIGIT_W:0]       shifted;
    logic                   fits;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[VALUE_WIDTH-1]};
        fits      = shifted >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST_STEP;
            q_next    = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits in a digit.
            rem_next = fits ? DIGIT_W'(shifted - {1'b0, div_reg}) : shifted[DIGIT_W-1:0];
            q_next   = {q_reg[VALUE_WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/integer_to_ascii_radix_top.sv -----
// ============================================================================
// integer_to_ascii_radix_top
// Converts a signed integer to ASCII text in a programmable radix.
// ============================================================================
// Usage:
//   Write the radix (2 to 36; smaller codes act as 2, larger as 36) through
//   radix_wr_en/radix_wr_data while the block is idle. Each transfer on the
//   number channel yields the text of the value on the text channel, most
//   significant character first, last set on the final character. In radix
//   10 a negative value is preceded by '-'; other radixes read the bit
//   pattern as unsigned. Zero gives the single character '0'.
//   Each digit costs one pass through the shared bit-serial divider.
//   Characters then leave one per cycle through the output register
//   while the text receiver is ready.
//   number.ready is high only while no conversion is running; a stalled
//   text receiver holds the output register and the sequencer waits.
//   Reset sets the radix to 10, empties the output and returns to idle.
// ============================================================================
`default_nettype none

module integer_to_ascii_radix_top #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          radix_wr_en,
    input  wire logic [itoa_pkg::DIGIT_W-1:0]  radix_wr_data,
    itoa_in_if.sink                            number,
    itoa_out_if.source                         text
);
    import itoa_pkg::*;

    localparam int IW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_SIGN, ST_EMIT} state_t;

    state_t              state_reg;
    logic [DIGIT_W-1:0]  radix_reg;
    logic [CW-1:0]       count_reg;
    logic                neg_reg;
    logic                out_valid_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic                last_reg;
    logic [DIGIT_W-1:0]  store_reg [VALUE_WIDTH];

    logic [DIGIT_W-1:0]     eff_radix;
    logic                   slot_free;
    logic                   in_take;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_raw;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [DIGIT_W-1:0]     div_rem;
    logic [CW-1:0]          count_dec;
    logic                   sign_load;
    logic                   emit_load;

    always_comb
    begin
        priority if (radix_reg < RADIX_MIN)
        begin
            eff_radix = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            eff_radix = RADIX_MAX;
        end
        else
        begin
            eff_radix = radix_reg;
        end
    end

    assign number.ready = (state_reg == ST_IDLE);
    assign in_take      = number.valid && (state_reg == ST_IDLE);
    assign in_raw       = number.value;
    assign in_neg       = (eff_radix == RADIX_DECIMAL) && in_raw[VALUE_WIDTH-1];
    // The most negative value negates to itself, which read unsigned is exact.
    assign in_mag       = in_neg ? ('0 - in_raw) : in_raw;

    assign slot_free    = !out_valid_reg || text.ready;
    assign div_dividend = (state_reg == ST_IDLE) ? in_mag : div_quot;
    assign div_start    = (in_take && (in_mag != '0))
                       || ((state_reg == ST_DIVIDE) && div_done && (div_quot != '0));
    assign count_dec    = count_reg - 1'b1;
    assign sign_load    = (state_reg == ST_SIGN) && slot_free;
    assign emit_load    = (state_reg == ST_EMIT) && slot_free && (count_reg != '0);

    itoa_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_radix),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (radix_wr_en)
            begin
                radix_reg <= radix_wr_data;
            end
            if (sign_load || emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        neg_reg <= in_neg;
                        if (in_mag == '0)
                        begin
                            count_reg <= CW'(1);
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            count_reg <= '0;
                            state_reg <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (div_quot == '0)
                        begin
                            state_reg <= neg_reg ? ST_SIGN : ST_EMIT;
                        end
                    end
                end
                ST_SIGN:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (count_reg == '0)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (slot_free)
                    begin
                        count_reg <= count_dec;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Digits are stored least significant first and read back in reverse.
    always_ff @(posedge clk)
    begin
        if (in_take && (in_mag == '0))
        begin
            store_reg[0] <= '0;
        end
        else if ((state_reg == ST_DIVIDE) && div_done)
        begin
            store_reg[count_reg[IW-1:0]] <= div_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sign_load)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            char_reg <= digit_to_char(store_reg[count_dec[IW-1:0]]);
            last_reg <= (count_reg == CW'(1));
        end
    end

    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

endmodule

`default_nettype wire
